### rtl/char_lcd_nibble_sequencer_assert.svh
// Assertion macros used by the checker file.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCDNS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("lcd sequencer check failed");

// Next-cycle implication, disabled during reset.
`define LCDNS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("lcd sequencer check failed");

`endif

### rtl/lcdns_pkg.sv
package lcdns_pkg;

  // Request codes
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FUNC  = 2'd0;
  localparam logic [1:0] CFG_ENTRY = 2'd1;
  localparam logic [1:0] CFG_DISP  = 2'd2;

  localparam logic [7:0] FUNC_RESET  = 8'h28;
  localparam logic [7:0] ENTRY_RESET = 8'h06;
  localparam logic [7:0] DISP_RESET  = 8'h0C;
  localparam logic [7:0] CLEAR_WORD  = 8'h01;

  // Hold times in microseconds
  localparam logic [13:0] US_STROBE  = 14'd1;
  localparam logic [13:0] US_SETTLE  = 14'd40;
  localparam logic [13:0] US_CLEAR   = 14'd2040;
  localparam logic [13:0] US_WAIT1   = 14'd5000;
  localparam logic [13:0] US_WAIT2   = 14'd1000;
  localparam logic [13:0] US_POWERUP = 14'd15000;

  localparam int StepW = 6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable;
    logic [3:0]  data_nibble;
    logic [13:0] hold_us;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    NIB_BUS,
    NIB_CONST,
    NIB_HI,
    NIB_LO
  } nib_src_e;

  typedef enum logic [2:0] {
    BYTE_VALUE,
    BYTE_FUNC,
    BYTE_ENTRY,
    BYTE_DISP,
    BYTE_CLEAR
  } byte_src_e;

  typedef enum logic [2:0] {
    HOLD_STROBE,
    HOLD_SETTLE,
    HOLD_CLEAR,
    HOLD_WAIT1,
    HOLD_WAIT2,
    HOLD_POWERUP
  } hold_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // One microcode control word
  typedef struct packed {
    logic      rs;
    logic      en;
    nib_src_e  nib_src;
    logic [3:0] nib_const;
    byte_src_e byte_src;
    hold_e     hold;
    logic      last;
  } ctrl_t;

  // Program entry points
  localparam logic [StepW-1:0] ENTRY_INIT  = 6'd0;
  localparam logic [StepW-1:0] ENTRY_CLEAR = 6'd21;
  localparam logic [StepW-1:0] ENTRY_WRITE = 6'd25;
  localparam logic [StepW-1:0] ENTRY_DATA  = 6'd29;

  function automatic ctrl_t mk(logic rs, logic en, nib_src_e ns, logic [3:0] nc,
                               byte_src_e bs, hold_e h, logic last);
    ctrl_t c;
    c.rs        = rs;
    c.en        = en;
    c.nib_src   = ns;
    c.nib_const = nc;
    c.byte_src  = bs;
    c.hold      = h;
    c.last      = last;
    return c;
  endfunction

  function automatic logic [StepW-1:0] entry_step(logic [1:0] cmd);
    logic [StepW-1:0] s;
    case (cmd)
      CMD_INIT:  s = ENTRY_INIT;
      CMD_DATA:  s = ENTRY_DATA;
      CMD_WRITE: s = ENTRY_WRITE;
      CMD_CLEAR: s = ENTRY_CLEAR;
      default:   s = ENTRY_CLEAR;
    endcase
    return s;
  endfunction

  // Microcode program: init 0..24 (clear tail 21..24), command 25..28, data 29..32
  function automatic ctrl_t ucode(logic [StepW-1:0] step);
    ctrl_t c;
    case (step)
      6'd0:  c = mk(1'b1, 1'b0, NIB_BUS,   4'h0, BYTE_VALUE, HOLD_POWERUP, 1'b0);
      6'd1:  c = mk(1'b0, 1'b1, NIB_CONST, 4'h3, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd2:  c = mk(1'b0, 1'b0, NIB_CONST, 4'h3, BYTE_VALUE, HOLD_WAIT1,   1'b0);
      6'd3:  c = mk(1'b0, 1'b1, NIB_CONST, 4'h3, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd4:  c = mk(1'b0, 1'b0, NIB_CONST, 4'h3, BYTE_VALUE, HOLD_WAIT2,   1'b0);
      6'd5:  c = mk(1'b0, 1'b1, NIB_CONST, 4'h3, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd6:  c = mk(1'b0, 1'b0, NIB_CONST, 4'h3, BYTE_VALUE, HOLD_SETTLE,  1'b0);
      6'd7:  c = mk(1'b0, 1'b1, NIB_CONST, 4'h2, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd8:  c = mk(1'b0, 1'b0, NIB_CONST, 4'h2, BYTE_VALUE, HOLD_SETTLE,  1'b0);
      6'd9:  c = mk(1'b0, 1'b1, NIB_HI,    4'h0, BYTE_FUNC,  HOLD_STROBE,  1'b0);
      6'd10: c = mk(1'b0, 1'b0, NIB_HI,    4'h0, BYTE_FUNC,  HOLD_STROBE,  1'b0);
      6'd11: c = mk(1'b0, 1'b1, NIB_LO,    4'h0, BYTE_FUNC,  HOLD_STROBE,  1'b0);
      6'd12: c = mk(1'b0, 1'b0, NIB_LO,    4'h0, BYTE_FUNC,  HOLD_SETTLE,  1'b0);
      6'd13: c = mk(1'b0, 1'b1, NIB_HI,    4'h0, BYTE_ENTRY, HOLD_STROBE,  1'b0);
      6'd14: c = mk(1'b0, 1'b0, NIB_HI,    4'h0, BYTE_ENTRY, HOLD_STROBE,  1'b0);
      6'd15: c = mk(1'b0, 1'b1, NIB_LO,    4'h0, BYTE_ENTRY, HOLD_STROBE,  1'b0);
      6'd16: c = mk(1'b0, 1'b0, NIB_LO,    4'h0, BYTE_ENTRY, HOLD_SETTLE,  1'b0);
      6'd17: c = mk(1'b0, 1'b1, NIB_HI,    4'h0, BYTE_DISP,  HOLD_STROBE,  1'b0);
      6'd18: c = mk(1'b0, 1'b0, NIB_HI,    4'h0, BYTE_DISP,  HOLD_STROBE,  1'b0);
      6'd19: c = mk(1'b0, 1'b1, NIB_LO,    4'h0, BYTE_DISP,  HOLD_STROBE,  1'b0);
      6'd20: c = mk(1'b0, 1'b0, NIB_LO,    4'h0, BYTE_DISP,  HOLD_SETTLE,  1'b0);
      6'd21: c = mk(1'b0, 1'b1, NIB_HI,    4'h0, BYTE_CLEAR, HOLD_STROBE,  1'b0);
      6'd22: c = mk(1'b0, 1'b0, NIB_HI,    4'h0, BYTE_CLEAR, HOLD_STROBE,  1'b0);
      6'd23: c = mk(1'b0, 1'b1, NIB_LO,    4'h0, BYTE_CLEAR, HOLD_STROBE,  1'b0);
      6'd24: c = mk(1'b0, 1'b0, NIB_LO,    4'h0, BYTE_CLEAR, HOLD_CLEAR,   1'b1);
      6'd25: c = mk(1'b0, 1'b1, NIB_HI,    4'h0, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd26: c = mk(1'b0, 1'b0, NIB_HI,    4'h0, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd27: c = mk(1'b0, 1'b1, NIB_LO,    4'h0, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd28: c = mk(1'b0, 1'b0, NIB_LO,    4'h0, BYTE_VALUE, HOLD_SETTLE,  1'b1);
      6'd29: c = mk(1'b1, 1'b1, NIB_HI,    4'h0, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd30: c = mk(1'b1, 1'b0, NIB_HI,    4'h0, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd31: c = mk(1'b1, 1'b1, NIB_LO,    4'h0, BYTE_VALUE, HOLD_STROBE,  1'b0);
      6'd32: c = mk(1'b1, 1'b0, NIB_LO,    4'h0, BYTE_VALUE, HOLD_SETTLE,  1'b1);
      default: c = mk(1'b1, 1'b0, NIB_BUS, 4'h0, BYTE_VALUE, HOLD_SETTLE,  1'b1);
    endcase
    return c;
  endfunction

endpackage

### rtl/lcdns_sequencer.sv
module lcdns_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [1:0]                       cmd_i,
  input  logic                             advance_i,
  output logic                             busy_o,
  output lcdns_pkg::ctrl_t                 ctrl_o
);

  lcdns_pkg::seq_state_e              state_q, state_d;
  logic [lcdns_pkg::StepW-1:0]        step_q, step_d;

  // Fetch the control word of the current step
  assign ctrl_o = lcdns_pkg::ucode(step_q);

  // Next state: run from the entry point until a word marked last is issued
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcdns_pkg::SEQ_IDLE: if (start_i) state_d = lcdns_pkg::SEQ_RUN;
      lcdns_pkg::SEQ_RUN:  if (advance_i && ctrl_o.last) state_d = lcdns_pkg::SEQ_IDLE;
      default:             state_d = lcdns_pkg::SEQ_IDLE;
    endcase
  end

  // Step counter: jump to entry on start, advance on each issued word but the last
  always_comb begin
    step_d = step_q;
    if (start_i) begin
      step_d = lcdns_pkg::entry_step(cmd_i);
    end else if (advance_i && !ctrl_o.last) begin
      step_d = step_q + 1'b1;
    end
  end

  // Outputs
  always_comb begin
    case (state_q)
      lcdns_pkg::SEQ_RUN: busy_o = 1'b1;
      default:            busy_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcdns_pkg::SEQ_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### rtl/lcdns_datapath.sv
module lcdns_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcdns_pkg::ctrl_t  ctrl_i,
  input  logic              load_i,
  input  logic              capture_i,
  input  logic [7:0]        value_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output lcdns_pkg::out_t   out_data_o,
  output logic              beat_ready_o
);

  logic [7:0]       func_q, entry_q, disp_q;
  logic [7:0]       value_q;
  logic [3:0]       bus_nibble_q;
  logic             out_valid_q, out_valid_d;
  lcdns_pkg::out_t  out_q, out_d;
  logic [7:0]       byte_sel;
  logic [3:0]       nib_sel;
  logic [13:0]      hold_sel;

  // Pick the byte being sent
  always_comb begin
    case (ctrl_i.byte_src)
      lcdns_pkg::BYTE_FUNC:  byte_sel = func_q;
      lcdns_pkg::BYTE_ENTRY: byte_sel = entry_q;
      lcdns_pkg::BYTE_DISP:  byte_sel = disp_q;
      lcdns_pkg::BYTE_CLEAR: byte_sel = lcdns_pkg::CLEAR_WORD;
      default:               byte_sel = value_q;
    endcase
  end

  // Pick the nibble on the bus
  always_comb begin
    case (ctrl_i.nib_src)
      lcdns_pkg::NIB_CONST: nib_sel = ctrl_i.nib_const;
      lcdns_pkg::NIB_HI:    nib_sel = byte_sel[7:4];
      lcdns_pkg::NIB_LO:    nib_sel = byte_sel[3:0];
      default:              nib_sel = bus_nibble_q;
    endcase
  end

  // Decode hold time
  always_comb begin
    case (ctrl_i.hold)
      lcdns_pkg::HOLD_SETTLE:  hold_sel = lcdns_pkg::US_SETTLE;
      lcdns_pkg::HOLD_CLEAR:   hold_sel = lcdns_pkg::US_CLEAR;
      lcdns_pkg::HOLD_WAIT1:   hold_sel = lcdns_pkg::US_WAIT1;
      lcdns_pkg::HOLD_WAIT2:   hold_sel = lcdns_pkg::US_WAIT2;
      lcdns_pkg::HOLD_POWERUP: hold_sel = lcdns_pkg::US_POWERUP;
      default:                 hold_sel = lcdns_pkg::US_STROBE;
    endcase
  end

  // Build the next beat and manage the output register
  always_comb begin
    out_d.reg_select  = ctrl_i.rs;
    out_d.enable      = ctrl_i.en;
    out_d.data_nibble = nib_sel;
    out_d.hold_us     = hold_sel;
    out_d.last        = ctrl_i.last;
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  assign beat_ready_o = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // Control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q       <= lcdns_pkg::FUNC_RESET;
      entry_q      <= lcdns_pkg::ENTRY_RESET;
      disp_q       <= lcdns_pkg::DISP_RESET;
      bus_nibble_q <= 4'h0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load_i) bus_nibble_q <= nib_sel;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcdns_pkg::CFG_FUNC:  func_q  <= cfg_wdata_i;
          lcdns_pkg::CFG_ENTRY: entry_q <= cfg_wdata_i;
          lcdns_pkg::CFG_DISP:  disp_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (capture_i) value_q <= value_i;
    if (load_i) out_q <= out_d;
  end

endmodule

### rtl/char_lcd_nibble_sequencer.sv
// Character LCD sequencer for a 4-bit bus. Each accepted request is expanded into a
// list of pin-state beats (register select, enable, data nibble, hold time in us),
// the final beat of a request flagged by last. A microcode step counter issues one
// control word per cycle while the output is not stalled; a data, command or clear
// request has 4 beats and the init sequence 25 beats. The next request is taken in
// the cycle after the last beat enters the output register. Config writes go to
// index 0 (function set), 1 (entry mode) and 2 (display control) and must be
// made while no request is in progress.
module char_lcd_nibble_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lcdns_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lcdns_pkg::out_t  out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_wdata_i
);

  logic             busy;
  logic             beat_ready;
  logic             in_fire;
  logic             advance;
  lcdns_pkg::ctrl_t ctrl;

  // Accept only between requests; issue a word when the output register frees up
  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign advance    = busy && beat_ready;

  lcdns_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire),
    .cmd_i     (in_data_i.cmd),
    .advance_i (advance),
    .busy_o    (busy),
    .ctrl_o    (ctrl)
  );

  lcdns_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .load_i       (advance),
    .capture_i    (in_fire),
    .value_i      (in_data_i.value),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .beat_ready_o (beat_ready)
  );

endmodule

### rtl/lcdns_checker.sv
`include "char_lcd_nibble_sequencer_assert.svh"

module lcdns_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input lcdns_pkg::in_t   in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input lcdns_pkg::out_t  out_data_o,
  input logic             cfg_we_i,
  input logic [1:0]       cfg_idx_i,
  input logic [7:0]       cfg_wdata_i
);

  // Hold a stalled output beat
  `LCDNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Go busy right after taking a request
  `LCDNS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A pending beat that is not the last means the request is still running
  `LCDNS_ASSERT_IMPL(a_busy_mid_request, clk_i, rst_ni, out_valid_o && !out_data_o.last, in_stall_o)

  // Enable strobes last one microsecond
  `LCDNS_ASSERT_IMPL(a_strobe_width, clk_i, rst_ni, out_valid_o && out_data_o.enable, out_data_o.hold_us == 14'd1)

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (.*);

### sim/char_lcd_nibble_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;

  // Low-phase hold after the high nibble of a byte
  localparam logic [13:0] GapUs = 14'd1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  lcdns_pkg::in_t      in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lcdns_pkg::out_t     out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [1:0]          cfg_idx_i   = '0;
  logic [7:0]          cfg_wdata_i = '0;

  char_lcd_nibble_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be offered and pin states waiting to come out
  lcdns_pkg::in_t  request_q[$];
  lcdns_pkg::out_t pin_state_q[$];

  // Mirror of the sequencer state and its registers
  logic [7:0]      func_word;
  logic [7:0]      entry_word;
  logic [7:0]      disp_word;
  logic [3:0]      lcd_bus_nibble;
  logic            lcd_rs_idle;
  lcdns_pkg::out_t held_pin;
  bit              pin_held;

  bit in_taken;
  bit out_taken;
  bit no_idle;
  int send_gap;
  int rx_wait;
  int rx_hold;
  int fail_count;

  initial begin
    func_word      = lcdns_pkg::FUNC_RESET;
    entry_word     = lcdns_pkg::ENTRY_RESET;
    disp_word      = lcdns_pkg::DISP_RESET;
    lcd_bus_nibble = 4'h0;
    lcd_rs_idle    = 1'b1;
    pin_held       = 1'b0;
    no_idle        = 1'b0;
    send_gap       = 0;
    rx_wait        = 0;
    rx_hold        = 0;
    fail_count     = 0;
  end

  // Queue one pin state; the previous one is released so the final one can be flagged
  task automatic emit_pin(input logic rs, input logic en, input logic [3:0] nib,
                          input logic [13:0] hold);
    if (pin_held) pin_state_q.push_back(held_pin);
    held_pin.reg_select  = rs;
    held_pin.enable      = en;
    held_pin.data_nibble = nib;
    held_pin.hold_us     = hold;
    held_pin.last        = 1'b0;
    pin_held             = 1'b1;
    lcd_bus_nibble       = nib;
  endtask

  task automatic emit_nibble(input logic rs, input logic [3:0] nib,
                             input logic [13:0] low_hold);
    emit_pin(rs, 1'b1, nib, lcdns_pkg::US_STROBE);
    emit_pin(rs, 1'b0, nib, low_hold);
  endtask

  task automatic emit_byte(input logic rs, input logic [7:0] b, input logic [13:0] tail);
    emit_nibble(rs, b[7:4], GapUs);
    emit_nibble(rs, b[3:0], tail);
  endtask

  task automatic emit_command(input logic [7:0] b, input logic [13:0] tail);
    lcd_rs_idle = 1'b0;
    emit_byte(1'b0, b, tail);
    lcd_rs_idle = 1'b1;
  endtask

  // Expand one request into the pin states it should produce
  task automatic expand_request(input lcdns_pkg::in_t req);
    pin_held = 1'b0;
    case (req.cmd)
      lcdns_pkg::CMD_INIT: begin
        lcd_rs_idle = 1'b1;
        emit_pin(1'b1, 1'b0, lcd_bus_nibble, lcdns_pkg::US_POWERUP);
        lcd_rs_idle = 1'b0;
        emit_nibble(1'b0, 4'h3, lcdns_pkg::US_WAIT1);
        emit_nibble(1'b0, 4'h3, lcdns_pkg::US_WAIT2);
        emit_nibble(1'b0, 4'h3, lcdns_pkg::US_SETTLE);
        emit_nibble(1'b0, 4'h2, lcdns_pkg::US_SETTLE);
        emit_command(func_word, lcdns_pkg::US_SETTLE);
        emit_command(entry_word, lcdns_pkg::US_SETTLE);
        emit_command(disp_word, lcdns_pkg::US_SETTLE);
        emit_command(lcdns_pkg::CLEAR_WORD, lcdns_pkg::US_CLEAR);
      end
      lcdns_pkg::CMD_DATA:  emit_byte(lcd_rs_idle, req.value, lcdns_pkg::US_SETTLE);
      lcdns_pkg::CMD_WRITE: emit_command(req.value, lcdns_pkg::US_SETTLE);
      default:              emit_command(lcdns_pkg::CLEAR_WORD, lcdns_pkg::US_CLEAR);
    endcase
    held_pin.last = 1'b1;
    pin_state_q.push_back(held_pin);
    pin_held = 1'b0;
  endtask

  // Compare one pin-state beat against the oldest expectation
  task automatic check_pin(input lcdns_pkg::out_t got);
    lcdns_pkg::out_t want;
    if (pin_state_q.size() == 0) begin
      $error("pin state beat with nothing expected: %h", got);
      fail_count++;
    end else begin
      want = pin_state_q.pop_front();
      if (got.reg_select !== want.reg_select) begin
        $error("reg_select: expected %0d, actual %0d", want.reg_select, got.reg_select);
        fail_count++;
      end
      if (got.enable !== want.enable) begin
        $error("enable: expected %0d, actual %0d", want.enable, got.enable);
        fail_count++;
      end
      if (got.data_nibble !== want.data_nibble) begin
        $error("data_nibble: expected %0h, actual %0h", want.data_nibble, got.data_nibble);
        fail_count++;
      end
      if (got.hold_us !== want.hold_us) begin
        $error("hold_us: expected %0d, actual %0d", want.hold_us, got.hold_us);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        fail_count++;
      end
    end
  endtask

  // Sample both handshakes; check outgoing beats before predicting new ones
  always @(posedge clk_i) begin
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (out_taken) check_pin(out_data_o);
    if (in_taken) expand_request(in_data_i);
  end

  // Offer requests from the queue, with a random gap after each accepted request
  always @(negedge clk_i) begin
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i && !in_taken;
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0) begin
          in_data_i <= request_q.pop_front();
          offer     = 1'b1;
          send_gap  = no_idle ? 0 : $urandom_range(0, 3);
        end
      end
      in_valid_i <= offer;
    end
  end

  // Stall the output at random, and hold it off for long stretches on demand
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_taken) rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_request(input logic [1:0] cmd, input logic [7:0] value);
    lcdns_pkg::in_t req;
    req.cmd   = cmd;
    req.value = value;
    request_q.push_back(req);
  endtask

  task automatic add_random_requests(input int count);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) add_request(lcdns_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
      else if (pick < 50) add_request(lcdns_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
      else if (pick < 80) add_request(lcdns_pkg::CMD_WRITE, 8'($urandom_range(0, 255)));
      else add_request(lcdns_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
    end
  endtask

  // Wait until every request went in and every pin state came out
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || pin_state_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      lcdns_pkg::CFG_FUNC:  func_word  = val;
      lcdns_pkg::CFG_ENTRY: entry_word = val;
      lcdns_pkg::CFG_DISP:  disp_word  = val;
      default: ;
    endcase
  endtask

  task automatic randomize_regs();
    int k;
    for (k = 0; k < 3; k++) write_reg(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: init from a zero bus, byte extremes, select return after commands
    add_request(lcdns_pkg::CMD_INIT, 8'hFF);
    add_request(lcdns_pkg::CMD_DATA, 8'h00);
    add_request(lcdns_pkg::CMD_DATA, 8'hFF);
    add_request(lcdns_pkg::CMD_WRITE, 8'h00);
    add_request(lcdns_pkg::CMD_DATA, 8'hA5);
    add_request(lcdns_pkg::CMD_WRITE, 8'hFF);
    add_request(lcdns_pkg::CMD_CLEAR, 8'hFF);
    add_request(lcdns_pkg::CMD_DATA, 8'h7E);
    add_request(lcdns_pkg::CMD_INIT, 8'h3C);
    add_request(lcdns_pkg::CMD_WRITE, 8'h5A);
    add_request(lcdns_pkg::CMD_CLEAR, 8'h00);
    wait_drained();

    // Low extreme for function set, out-of-range index must be ignored
    write_reg(lcdns_pkg::CFG_FUNC, 8'h00);
    write_reg(lcdns_pkg::CFG_ENTRY, 8'hFF);
    write_reg(lcdns_pkg::CFG_DISP, 8'hA5);
    write_reg(2'd3, 8'h5A);
    add_request(lcdns_pkg::CMD_DATA, 8'hC3);
    add_request(lcdns_pkg::CMD_INIT, 8'h00);
    add_request(lcdns_pkg::CMD_WRITE, 8'h12);
    wait_drained();

    write_reg(lcdns_pkg::CFG_FUNC, 8'hFF);
    write_reg(lcdns_pkg::CFG_ENTRY, 8'h00);
    write_reg(lcdns_pkg::CFG_DISP, 8'h00);
    add_request(lcdns_pkg::CMD_DATA, 8'h0F);
    add_request(lcdns_pkg::CMD_INIT, 8'h81);
    add_request(lcdns_pkg::CMD_DATA, 8'hF0);
    add_request(lcdns_pkg::CMD_INIT, 8'h00);
    wait_drained();

    // Random traffic with random idling
    randomize_regs();
    add_random_requests(28);
    wait_drained();

    // Back to back, no idling on either side
    randomize_regs();
    no_idle = 1'b1;
    add_random_requests(28);
    wait_drained();
    no_idle = 1'b0;

    // Long receiver hold-off while requests keep coming
    randomize_regs();
    rx_hold = 150;
    add_random_requests(28);
    wait_drained();

    // Sender pauses mid-stream until everything has drained
    randomize_regs();
    add_random_requests(14);
    wait_drained();
    add_random_requests(15);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
